FILE: sv/lodxf_pkg.sv
package lodxf_pkg;

  localparam int LodLevels = 16;

  localparam int LevelMaxInt = (LodLevels > 16) ? 15 : LodLevels - 1;
  localparam logic [3:0] LevelMax = 4'(LevelMaxInt);

  localparam logic [16:0] Q16One = 17'd65536;
  localparam logic [17:0] ThreeQ16 = 18'd196608;

  localparam logic [1:0] CfgCoverageThreshold = 2'd0;
  localparam logic [1:0] CfgHoldTime = 2'd1;
  localparam logic [1:0] CfgFadeSpeed = 2'd2;

  localparam logic [15:0] FadeSpeedReset = 16'd256;

  typedef struct packed {
    logic [3:0]  chosen_level;
    logic [15:0] coverage;
    logic [15:0] elapsed;
  } in_t;

  typedef struct packed {
    logic [3:0]  level_now;
    logic [3:0]  level_goal;
    logic [16:0] blend;
    logic        fading;
  } out_t;

  typedef struct packed {
    logic accept;
    logic ramp;
    logic square;
    logic mult;
    logic load;
  } cmd_t;

endpackage

FILE: sv/lodxf_ctrl.sv
module lodxf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lodxf_pkg::cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    SIdle,
    SRamp,
    SSquare,
    SMult,
    SDone
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;
  logic   accept;
  logic   load;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign load       = (state_q == SDone) && out_free;
  assign in_stall_o = !((state_q == SIdle) || load);
  assign accept     = in_valid_i && !in_stall_o;

  assign cmd_o.accept = accept;
  assign cmd_o.ramp   = (state_q == SRamp);
  assign cmd_o.square = (state_q == SSquare);
  assign cmd_o.mult   = (state_q == SMult);
  assign cmd_o.load   = load;

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        SIdle: begin
          if (accept) begin
            state_q <= SRamp;
          end
        end
        SRamp: begin
          state_q <= SSquare;
        end
        SSquare: begin
          state_q <= SMult;
        end
        SMult: begin
          state_q <= SDone;
        end
        SDone: begin
          if (accept) begin
            state_q <= SRamp;
          end else if (load) begin
            state_q <= SIdle;
          end
        end
        default: begin
          state_q <= SIdle;
        end
      endcase
    end
  end

  a_accept_starts_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == SRamp)
    else $error("accepted transaction did not start the update sequence");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_q)
    else $error("result load did not raise output valid");

  a_no_accept_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SRamp || state_q == SSquare || state_q == SMult) |-> in_stall_o)
    else $error("input accepted while an update is in progress");

endmodule

FILE: sv/lodxf_datapath.sv
module lodxf_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [19:0]       cfg_data_i,
  input  lodxf_pkg::in_t    in_data_i,
  input  lodxf_pkg::cmd_t   cmd_i,
  output lodxf_pkg::out_t   out_data_o
);

  logic [15:0]        thr_q;
  logic [19:0]        hold_time_q;
  logic [15:0]        speed_q;

  logic [3:0]         cur_q;
  logic [3:0]         target_q;
  logic [16:0]        prog_q;
  logic signed [21:0] hold_q;
  logic [15:0]        last_cov_q;

  logic [31:0]        prod_q;
  logic [33:0]        tt_q;
  logic [17:0]        f_q;
  logic [51:0]        p_q;
  lodxf_pkg::out_t    out_q;

  logic [3:0]         chosen;
  logic [15:0]        diff;
  logic               significant;
  logic signed [21:0] hold_dec;
  logic               start;
  logic [24:0]        np;
  logic [51:0]        rnd;

  always_comb begin
    chosen = (in_data_i.chosen_level > lodxf_pkg::LevelMax) ? lodxf_pkg::LevelMax
                                                             : in_data_i.chosen_level;
    diff = (in_data_i.coverage >= last_cov_q) ? in_data_i.coverage - last_cov_q
                                              : last_cov_q - in_data_i.coverage;
    significant = diff >= thr_q;
    hold_dec = hold_q;
    if (hold_q > 22'sd0) begin
      hold_dec = hold_q - $signed({6'b0, in_data_i.elapsed});
    end
    start = (chosen != target_q) && (hold_dec <= 22'sd0) && significant;
    np  = {8'b0, prog_q} + {1'b0, prod_q[31:8]};
    rnd = p_q + (52'd1 << 31);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= '0;
      hold_time_q <= '0;
      speed_q     <= lodxf_pkg::FadeSpeedReset;
      cur_q       <= '0;
      target_q    <= '0;
      prog_q      <= lodxf_pkg::Q16One;
      hold_q      <= '0;
      last_cov_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          lodxf_pkg::CfgCoverageThreshold: thr_q       <= cfg_data_i[15:0];
          lodxf_pkg::CfgHoldTime:          hold_time_q <= cfg_data_i;
          lodxf_pkg::CfgFadeSpeed:         speed_q     <= cfg_data_i[15:0];
          default: begin
          end
        endcase
      end
      if (cmd_i.accept) begin
        last_cov_q <= in_data_i.coverage;
        if (start) begin
          cur_q    <= target_q;
          target_q <= chosen;
          prog_q   <= '0;
          hold_q   <= $signed({2'b0, hold_time_q});
        end else begin
          hold_q <= hold_dec;
        end
      end
      if (cmd_i.ramp && !prog_q[16]) begin
        if (np >= 25'(lodxf_pkg::Q16One)) begin
          prog_q <= lodxf_pkg::Q16One;
          cur_q  <= target_q;
        end else begin
          prog_q <= np[16:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      prod_q <= {16'b0, speed_q} * {16'b0, in_data_i.elapsed};
    end
    if (cmd_i.square) begin
      tt_q <= {17'b0, prog_q} * {17'b0, prog_q};
      f_q  <= lodxf_pkg::ThreeQ16 - {prog_q, 1'b0};
    end
    if (cmd_i.mult) begin
      p_q <= {18'b0, tt_q} * {34'b0, f_q};
    end
    if (cmd_i.load) begin
      out_q.level_now  <= cur_q;
      out_q.level_goal <= target_q;
      out_q.blend      <= rnd[48:32];
      out_q.fading     <= !prog_q[16];
    end
  end

  assign out_data_o = out_q;

  a_progress_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prog_q <= lodxf_pkg::Q16One)
    else $error("progress exceeds one");

  a_hold_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_q >= -22'sd65535)
    else $error("hold timer dropped below its floor");

  a_settled_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (prog_q == lodxf_pkg::Q16One) |-> (cur_q == target_q))
    else $error("levels differ although the transition has finished");

endmodule

FILE: sv/lod_crossfade_controller.sv
// Detail-level crossfade controller with hysteresis. Each input transaction carries the
// selected level, the screen coverage and the elapsed time, and yields exactly one output
// transaction with both levels, the smoothstep blend factor and the fading flag. A
// transaction passes through these steps in order: the accept cycle makes the transition
// decision and the speed-times-time product, then come the progress ramp, the squaring of
// progress and the final smoothstep product; the result is loaded into the output register
// in the same cycle that the next transaction can be accepted. A stalled output register
// holds the block until the result is taken. Configuration writes are always ready and must
// be made only while the block is idle.
module lod_crossfade_controller (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [19:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  lodxf_pkg::in_t    in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lodxf_pkg::out_t   out_data_o
);

  lodxf_pkg::cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  lodxf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  lodxf_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .out_data_o  (out_data_o)
  );

endmodule
